### sv/ascp_pkg.sv
// ----------------------------------------------------------------------------
// ascp_pkg
// shared types and constants for the ascii command line parser
// ----------------------------------------------------------------------------
package ascp_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER     = 2'd0;
	localparam logic [1:0] KIND_DIGIT      = 2'd1;
	localparam logic [1:0] KIND_INCOMPLETE = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW   = 2'd3;

	// command classes
	localparam logic [1:0] CLASS_BUS    = 2'd0;
	localparam logic [1:0] CLASS_SYSTEM = 2'd1;
	localparam logic [1:0] CLASS_CONFIG = 2'd2;

	// ascii codes
	localparam logic [7:0] ASCII_NEWLINE = 8'h0A;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_ONE     = 8'h31;
	localparam logic [7:0] ASCII_NINE    = 8'h39;

	// line layout
	localparam int unsigned MIN_LINE_LEN = 4;
	localparam logic [5:0]  MAX_DIGITS   = 6'd59;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHORT,
		ST_HDR,
		ST_SCAN,
		ST_EMIT
	} ascp_state_t;

endpackage

### sv/ascii_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// ascii_command_line_parser_top
// line buffer and sequencer that parses one ascii command line per newline
// ----------------------------------------------------------------------------
// an ordinary byte is written to the line buffer and gives no result
// a short line or an overflow passes through ST_SHORT and gives its item once
// the output register is free; a full newline passes through ST_HDR and ST_SCAN,
// which gives one digit item per cycle while the output register is free, and
// ST_EMIT then loads the header item; the block is busy until the header item,
// or the item of a short line, is loaded into the output register
// arst_n clears the fill index, the sequencer and the output valid; the line
// buffer itself is not cleared and needs no clearing pass
module ascii_command_line_parser_top #(
	parameter int LINE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [1:0]         cmd_class,
	output logic signed [15:0] cmd_code,
	output logic signed [8:0]  rw_value,
	output logic               rw_ok,
	output logic [5:0]         data_length,
	output logic               digit_error,
	output logic [3:0]         data_digit,
	output logic               last
);
	import ascp_pkg::*;

	localparam int IW = $clog2(LINE_DEPTH);

	// line buffer, one write port in idle and one registered read port
	logic [7:0]    line_mem [LINE_DEPTH];
	logic [7:0]    rd_data_q;

	ascp_state_t   state_q, state_d;
	logic [IW-1:0] fill_q;
	logic [IW-1:0] count_q;
	logic [IW-1:0] ptr_q, ptr_d;
	logic [1:0]    short_kind_q;

	// header accumulators
	logic [1:0]         cls_q;
	logic signed [15:0] code_q;
	logic signed [8:0]  rw_q;
	logic               rwok_q;
	logic [5:0]         len_q;
	logic               derr_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [1:0]         ocls_q;
	logic signed [15:0] ocode_q;
	logic signed [8:0]  orw_q;
	logic               orwok_q;
	logic [5:0]         olen_q;
	logic               oderr_q;
	logic [3:0]         odigit_q;
	logic               olast_q;

	logic               accept;
	logic               out_free;
	logic               is_digit;
	logic signed [8:0]  dval;
	logic signed [15:0] code_next;
	logic               ld_short, ld_digit, ld_hdr;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// value of the buffered byte under the read pointer
	assign is_digit = (rd_data_q >= ASCII_ZERO) && (rd_data_q <= ASCII_NINE);
	assign dval     = $signed({1'b0, rd_data_q}) - $signed({1'b0, ASCII_ZERO});

	// shared multiply-by-ten and add unit for the three code digits
	assign code_next = (code_q <<< 3) + (code_q <<< 1) + 16'(dval);

	// sequencer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read pointer and output loads
	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		ld_short = 1'b0;
		ld_digit = 1'b0;
		ld_hdr   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ptr_d = '0;
				if (accept) begin
					if (rx_byte != ASCII_NEWLINE) begin
						if (fill_q == IW'(LINE_DEPTH - 1)) begin
							state_d = ST_SHORT;
						end
					end else if (fill_q < IW'(MIN_LINE_LEN)) begin
						state_d = ST_SHORT;
					end else begin
						state_d = ST_HDR;
					end
				end
			end
			ST_SHORT: begin
				ptr_d = '0;
				if (out_free) begin
					ld_short = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_HDR: begin
				// bytes 0 to 3, and byte 4 for bus lines
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == IW'(4)) begin
					state_d = ST_SCAN;
				end else if (ptr_q == IW'(3) && cls_q != CLASS_BUS) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ptr_q >= count_q || len_q == MAX_DIGITS) begin
					state_d = ST_EMIT;
				end else if (!is_digit) begin
					state_d = ST_EMIT;
				end else if (out_free) begin
					ld_digit = 1'b1;
					ptr_d    = ptr_q + 1'b1;
				end
			end
			ST_EMIT: begin
				ptr_d = '0;
				if (out_free) begin
					ld_hdr  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// line buffer write and registered read
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[fill_q] <= rx_byte;
		end
		rd_data_q <= line_mem[ptr_d];
	end

	// fill index and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
		end else begin
			ptr_q <= ptr_d;
			if (accept) begin
				if (rx_byte == ASCII_NEWLINE || fill_q == IW'(LINE_DEPTH - 1)) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// line length, short result kind and header accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			count_q      <= fill_q;
			short_kind_q <= (rx_byte == ASCII_NEWLINE) ? KIND_INCOMPLETE : KIND_OVERFLOW;
			cls_q        <= CLASS_CONFIG;
			code_q       <= '0;
			rw_q         <= '0;
			rwok_q       <= 1'b0;
			len_q        <= '0;
			derr_q       <= 1'b0;
		end
		if (state_q == ST_HDR) begin
			if (ptr_q == '0) begin
				if (rd_data_q == ASCII_ZERO) begin
					cls_q <= CLASS_BUS;
				end else if (rd_data_q == ASCII_ONE) begin
					cls_q <= CLASS_SYSTEM;
				end else begin
					cls_q <= CLASS_CONFIG;
				end
			end else if (ptr_q == IW'(4)) begin
				rw_q   <= dval;
				rwok_q <= (rd_data_q == ASCII_ZERO) || (rd_data_q == ASCII_ONE);
			end else begin
				code_q <= code_next;
			end
		end
		if (state_q == ST_SCAN && ptr_q < count_q && len_q != MAX_DIGITS && !is_digit) begin
			derr_q <= 1'b1;
		end
		if (ld_digit) begin
			len_q <= len_q + 1'b1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_short || ld_digit || ld_hdr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, unused fields zero
	always_ff @(posedge clk) begin
		if (ld_short) begin
			kind_q   <= short_kind_q;
			ocls_q   <= '0;
			ocode_q  <= '0;
			orw_q    <= '0;
			orwok_q  <= 1'b0;
			olen_q   <= '0;
			oderr_q  <= 1'b0;
			odigit_q <= '0;
			olast_q  <= 1'b1;
		end else if (ld_digit) begin
			kind_q   <= KIND_DIGIT;
			ocls_q   <= '0;
			ocode_q  <= '0;
			orw_q    <= '0;
			orwok_q  <= 1'b0;
			olen_q   <= '0;
			oderr_q  <= 1'b0;
			odigit_q <= rd_data_q[3:0];
			olast_q  <= 1'b0;
		end else if (ld_hdr) begin
			kind_q   <= KIND_HEADER;
			ocls_q   <= cls_q;
			ocode_q  <= code_q;
			orw_q    <= rw_q;
			orwok_q  <= rwok_q;
			olen_q   <= len_q;
			oderr_q  <= derr_q;
			odigit_q <= '0;
			olast_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign cmd_class   = ocls_q;
	assign cmd_code    = ocode_q;
	assign rw_value    = orw_q;
	assign rw_ok       = orwok_q;
	assign data_length = olen_q;
	assign digit_error = oderr_q;
	assign data_digit  = odigit_q;
	assign last        = olast_q;

endmodule
